>>> rtl/core/fdor_pkg.sv
// ----------------------------------------------------------------------------
// fdor_pkg
// Shared types and constants for the frame deframer with overwrite ring.
// ----------------------------------------------------------------------------
package fdor_pkg;

   localparam int RING_DEPTH_DEF     = 256;
   localparam int MAX_READ_BURST_DEF = 64;

   // Fixed frame layout
   localparam int FRAME_BYTES   = 64;
   localparam int POS_W         = 6;
   localparam int POS_TYPE      = 1;
   localparam int POS_LENGTH    = 3;
   localparam int PAYLOAD_START = 4;
   localparam int PAYLOAD_MAX   = 60;
   localparam logic [2:0] TYPE_DATA = 3'h2;

   localparam int HELD_W  = 9;
   localparam int QUEUE_DEPTH = 4;

   // Result status codes
   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   // Request opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_READ,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

endpackage

>>> rtl/core/fdor_front.sv
// ----------------------------------------------------------------------------
// fdor_front
// Accepts requests, tracks the frame layout and turns payload bytes and
// read requests into commands for the ring engine.
// ----------------------------------------------------------------------------
module fdor_front #(
   parameter int MAX_READ_BURST = fdor_pkg::MAX_READ_BURST_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // frame_byte[7:0], read_count[15:8]
   input  logic                req_tuser,   // opcode
   input  fdor_pkg::q_stat_type q_stat,
   output logic                cmd_push,
   output fdor_pkg::cmd_type   cmd
);
   import fdor_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       type_ff, type_in;
   logic [5:0]       len_ff, len_in;
   logic [7:0]       frame_byte, read_count;
   logic [POS_W-1:0] offset;
   logic [5:0]       limit;
   logic             accept, payload_push, bad_count;

   assign frame_byte = req_tdata[7:0];
   assign read_count = req_tdata[15:8];
   assign req_tready = ~q_stat.full;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      len_in  = len_ff;
      offset  = pos_ff - POS_W'(PAYLOAD_START);
      limit   = (len_ff < 6'(PAYLOAD_MAX)) ? len_ff : 6'(PAYLOAD_MAX);
      payload_push = (pos_ff >= POS_W'(PAYLOAD_START)) && (type_ff == TYPE_DATA) &&
                     (offset < limit);
      if (accept && req_tuser == OP_BYTE) begin
         if (pos_ff == POS_W'(POS_TYPE)) type_in = frame_byte[7:5];
         if (pos_ff == POS_W'(POS_LENGTH)) len_in = frame_byte[7:2];
         pos_in = (pos_ff == POS_W'(FRAME_BYTES - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   assign bad_count = (read_count == 8'd0) || (read_count > 8'(MAX_READ_BURST));

   always_comb begin
      cmd.value = frame_byte;
      cmd.kind  = CMD_PUSH;
      cmd_push  = 1'b0;
      if (accept) begin
         if (req_tuser == OP_READ) begin
            cmd.value = read_count;
            cmd.kind  = bad_count ? CMD_BAD : CMD_READ;
            cmd_push  = 1'b1;
         end else begin
            cmd_push  = payload_push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         type_ff <= '0;
         len_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         len_ff  <= len_in;
      end
   end

endmodule

>>> rtl/core/fdor_queue.sv
// ----------------------------------------------------------------------------
// fdor_queue
// Short command queue between the front and the ring engine.
// ----------------------------------------------------------------------------
module fdor_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fdor_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output fdor_pkg::cmd_type    head,
   output fdor_pkg::q_stat_type q_stat
);
   import fdor_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;
   logic            do_push, do_pop;

   assign q_stat.full  = (cnt_ff == CW'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head         = slot_ff[rd_ff];
   assign do_push      = push & ~q_stat.full;
   assign do_pop       = pop & ~q_stat.empty;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + CW'(do_push) - CW'(do_pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full))
      else $error("command pushed into a full queue");

endmodule

>>> rtl/core/fdor_back.sv
// ----------------------------------------------------------------------------
// fdor_back
// Ring engine: owns the byte ring and its pointers, executes pushes and
// read bursts, and holds the result register.
// ----------------------------------------------------------------------------
module fdor_back #(
   parameter int RING_DEPTH     = fdor_pkg::RING_DEPTH_DEF,
   parameter int MAX_READ_BURST = fdor_pkg::MAX_READ_BURST_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fdor_pkg::cmd_type    head,
   input  fdor_pkg::q_stat_type q_stat,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,  // data_byte[7:0], held_after[16:8], zero pad
   output logic [1:0]           rsp_tuser,  // status
   output logic                 rsp_tlast
);
   import fdor_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam int RW = $clog2(MAX_READ_BURST + 1);
   localparam int MW = (CW > 8) ? CW : 8;

   logic [7:0]      ring_mem [RING_DEPTH];
   logic [7:0]      rdata_ff;

   back_state_type  state_ff, state_in;
   logic [AW-1:0]   rd_ff, rd_in, wr_ff, wr_in, rd_nxt, wr_nxt;
   logic [CW-1:0]   held_ff, held_in;
   logic [RW-1:0]   remain_ff, remain_in;
   logic            vld_ff, vld_in;
   logic [1:0]      status_ff, status_in;
   logic            last_ff, last_in;
   logic [HELD_W-1:0] hafter_ff, hafter_in;
   logic            mem_we, mem_re, out_free, ring_full;
   logic [MW-1:0]   cnt_w, held_w;

   assign rd_nxt    = (rd_ff == AW'(RING_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign wr_nxt    = (wr_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign ring_full = (held_ff == CW'(RING_DEPTH));
   assign out_free  = ~vld_ff | rsp_tready;
   assign cnt_w     = MW'(head.value);
   assign held_w    = MW'(held_ff);

   always_comb begin
      state_in  = state_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      held_in   = held_ff;
      remain_in = remain_ff;
      vld_in    = vld_ff & ~rsp_tready;
      status_in = status_ff;
      last_in   = last_ff;
      hafter_in = hafter_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               case (head.kind)
                  CMD_PUSH: begin
                     mem_we = 1'b1;
                     wr_in  = wr_nxt;
                     // full ring: drop the oldest byte
                     if (ring_full) rd_in = rd_nxt;
                     else held_in = held_ff + 1'b1;
                     pop = 1'b1;
                  end
                  CMD_BAD: begin
                     if (out_free) begin
                        vld_in    = 1'b1;
                        status_in = ST_BAD;
                        last_in   = 1'b1;
                        hafter_in = HELD_W'(held_ff);
                        pop       = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (held_ff == '0) begin
                        if (out_free) begin
                           vld_in    = 1'b1;
                           status_in = ST_EMPTY;
                           last_in   = 1'b1;
                           hafter_in = '0;
                           pop       = 1'b1;
                        end
                     end else begin
                        remain_in = RW'((cnt_w < held_w) ? cnt_w : held_w);
                        state_in  = BK_READ;
                        pop       = 1'b1;
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               mem_re    = 1'b1;
               rd_in     = rd_nxt;
               held_in   = held_ff - 1'b1;
               remain_in = remain_ff - 1'b1;
               vld_in    = 1'b1;
               status_in = ST_DATA;
               last_in   = (remain_ff == RW'(1));
               hafter_in = HELD_W'(held_ff - 1'b1);
               if (remain_ff == RW'(1)) state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[wr_ff] <= head.value;
      if (mem_re) rdata_ff <= ring_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         rd_ff     <= '0;
         wr_ff     <= '0;
         held_ff   <= '0;
         remain_ff <= '0;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ff     <= rd_in;
         wr_ff     <= wr_in;
         held_ff   <= held_in;
         remain_ff <= remain_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      last_ff   <= last_in;
      hafter_ff <= hafter_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, hafter_ff, (status_ff == ST_DATA) ? rdata_ff : 8'd0};

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(RING_DEPTH))
      else $error("held count above ring depth");

   a_burst_sane: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_READ |-> (remain_ff != '0) && (held_ff != '0))
      else $error("burst active with nothing to pop");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      vld_ff && status_ff != ST_DATA |-> last_ff)
      else $error("status result without last marker");

endmodule

>>> rtl/core/frame_deframer_overwrite_ring.sv
// ----------------------------------------------------------------------------
// frame_deframer_overwrite_ring
// Splits payload bytes out of 64-byte link frames into a byte ring that
// overwrites its oldest byte when full, and serves read bursts from it.
// ----------------------------------------------------------------------------
// A request is accepted whenever the four-entry command queue has room; a
// frame byte that is not stored costs nothing further. The ring engine writes
// one payload byte per cycle while no read burst is active and pops one byte
// per cycle while the response output is free, through its single memory
// port, so a read of n bytes gives min(n, held) results after a setup step
// loading the burst count; empty and bad-count reads give one result. The
// ring is not cleared after reset: only bytes counted as held are ever read.
module frame_deframer_overwrite_ring #(
   parameter int RING_DEPTH     = fdor_pkg::RING_DEPTH_DEF,
   parameter int MAX_READ_BURST = fdor_pkg::MAX_READ_BURST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // frame_byte[7:0], read_count[15:8]
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data_byte[7:0], held_after[16:8], zero pad
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast
);
   import fdor_pkg::*;

   cmd_type    cmd, head;
   q_stat_type q_stat;
   logic       cmd_push, pop;

   fdor_front #(
      .MAX_READ_BURST(MAX_READ_BURST)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   fdor_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   fdor_back #(
      .RING_DEPTH     (RING_DEPTH),
      .MAX_READ_BURST (MAX_READ_BURST)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
